>>> design/command_frame_transmit_queue_defines.svh
// Assertion macros for the command frame transmit queue.
`ifndef COMMAND_FRAME_TRANSMIT_QUEUE_DEFINES_SVH
`define COMMAND_FRAME_TRANSMIT_QUEUE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define CFTQ_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled in reset
`define CFTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFTQ_ASSERT(lbl, clk, rst_n, ante, cons, msg)
`define CFTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/cftq_pkg.sv
// Shared constants and types of the command frame transmit queue.
package cftq_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int ADDR_MAX_W     = 8;

  localparam logic [7:0] START_BYTE_RST = 8'd170;

  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START2 = 3'd1;
  localparam logic [2:0] PH_CMD    = 3'd2;
  localparam logic [2:0] PH_D0     = 3'd3;
  localparam logic [2:0] PH_D1     = 3'd4;
  localparam logic [2:0] PH_D2     = 3'd5;
  localparam logic [2:0] PH_SUM    = 3'd6;

  localparam logic [3:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic                  we;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [31:0]           wdata;
    logic                  re;
    logic [ADDR_MAX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       byte_valid;
    logic       last_of_frame;
    logic       overflow;
    logic [3:0] queue_count;
  } res_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       empty;
  } sts_t;

endpackage

>>> design/cftq_if.sv
// Valid/ready channel interfaces for records in and frame bytes out.
interface cftq_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] command;
  logic [7:0] data0;
  logic [7:0] data1;
  logic [7:0] data2;

  modport source (output valid, operation, command, data0, data1, data2, input ready);
  modport sink   (input valid, operation, command, data0, data1, data2, output ready);
endinterface

interface cftq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       byte_valid;
  logic       last_of_frame;
  logic       overflow;
  logic [3:0] queue_count;

  modport source (output valid, tx_byte, byte_valid, last_of_frame, overflow, queue_count,
                  input ready);
  modport sink   (input valid, tx_byte, byte_valid, last_of_frame, overflow, queue_count,
                  output ready);
endinterface

>>> design/cftq_record_mem.sv
// Record store: one write port, one read port with registered read data.
module cftq_record_mem
  import cftq_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF,
  parameter int AW    = 4
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/cftq_framer.sv
// FIFO pointers and frame sequencer; builds one result per accepted word.
module cftq_framer
  import cftq_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int AW         = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        operation,
  input  logic [31:0] record,
  input  logic [7:0]  start_byte,
  input  logic [31:0] cur_record,
  output mem_req_t    mem_req,
  output res_t        res,
  output sts_t        sts
);

  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;
  logic [2:0]    phase_r, phase_nxt;
  logic          empty, full;
  logic [AW:0]   diff;
  logic [8:0]    diff_w;
  logic [7:0]    b0, b1, b2, b3;

  assign wp_inc = (wp_r == AW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == AW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign empty  = (wp_r == rp_r);
  assign full   = (wp_inc == rp_r);

  assign b0 = cur_record[7:0];
  assign b1 = cur_record[15:8];
  assign b2 = cur_record[23:16];
  assign b3 = cur_record[31:24];

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    phase_nxt     = phase_r;
    mem_req       = '0;
    mem_req.waddr = ADDR_MAX_W'(wp_r);
    mem_req.wdata = record;
    mem_req.raddr = ADDR_MAX_W'(rp_r);
    res           = '0;
    if (accept) begin
      if (operation == OP_ENQ) begin
        if (full) begin
          res.overflow = 1'b1;
        end else begin
          mem_req.we = 1'b1;
          wp_nxt     = wp_inc;
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (!empty) begin
              // record lands in the read register next cycle, well before PH_CMD
              mem_req.re     = 1'b1;
              rp_nxt         = rp_inc;
              res.tx_byte    = start_byte;
              res.byte_valid = 1'b1;
              phase_nxt      = PH_START2;
            end
          end
          PH_START2: begin
            res.tx_byte    = start_byte;
            res.byte_valid = 1'b1;
            phase_nxt      = PH_CMD;
          end
          PH_CMD, PH_D0, PH_D1, PH_D2: begin
            case (phase_r)
              PH_CMD:  res.tx_byte = b0;
              PH_D0:   res.tx_byte = b1;
              PH_D1:   res.tx_byte = b2;
              default: res.tx_byte = b3;
            endcase
            res.byte_valid = 1'b1;
            phase_nxt      = phase_r + 3'd1;
          end
          PH_SUM: begin
            res.tx_byte       = b0 + b1 + b2 + b3;
            res.byte_valid    = 1'b1;
            res.last_of_frame = 1'b1;
            phase_nxt         = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
    diff = (wp_nxt >= rp_nxt) ? ({1'b0, wp_nxt} - {1'b0, rp_nxt})
                              : ({1'b0, wp_nxt} + (AW+1)'(FIFO_DEPTH) - {1'b0, rp_nxt});
    diff_w = 9'(diff);
    res.queue_count = (diff_w > 9'(COUNT_MAX)) ? COUNT_MAX : diff_w[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      phase_r <= PH_IDLE;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign sts.phase = phase_r;
  assign sts.empty = empty;

endmodule

>>> design/command_frame_transmit_queue.sv
// Top level: command record queue with framed byte output.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    operation, command, data0, data1, data2
//   out_ch   out  valid/ready    tx_byte, byte_valid, last_of_frame, overflow, queue_count
//   cfg_*    in   write enable   start_byte
//
// Every accepted word yields one result word, registered in the output register;
// one word per cycle is taken while out_ch keeps up.
// in_ch.ready drops only while a result is held in the output register and out_ch stalls.
// A frame start reads the record store once; its registered read data feeds the frame.
// Synchronous reset empties the queue and returns the sequencer to idle; no clearing pass.
`include "command_frame_transmit_queue_defines.svh"
module command_frame_transmit_queue
  import cftq_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cftq_in_if.sink    in_ch,
  cftq_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic        accept;
  logic [7:0]  start_byte_r;
  logic [31:0] cur_record;
  mem_req_t    mem_req;
  res_t        res;
  sts_t        sts;
  logic        out_valid_r;
  res_t        out_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
    end else if (cfg_we) begin
      start_byte_r <= cfg_data;
    end
  end

  cftq_record_mem #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (cur_record)
  );

  cftq_framer #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .AW         (AW)
  ) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .operation  (in_ch.operation),
    .record     ({in_ch.data2, in_ch.data1, in_ch.data0, in_ch.command}),
    .start_byte (start_byte_r),
    .cur_record (cur_record),
    .mem_req    (mem_req),
    .res        (res),
    .sts        (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tx_byte       = out_r.tx_byte;
  assign out_ch.byte_valid    = out_r.byte_valid;
  assign out_ch.last_of_frame = out_r.last_of_frame;
  assign out_ch.overflow      = out_r.overflow;
  assign out_ch.queue_count   = out_r.queue_count;

  // a checksum word always sends the sequencer back to idle
  `CFTQ_ASSERT_NEXT(a_sum_ends_frame, clk, rst_n, accept && res.last_of_frame, sts.phase == PH_IDLE, "frame did not end after checksum")
  // a dropped record never carries a line byte
  `CFTQ_ASSERT(a_ovf_no_byte, clk, rst_n, accept && res.overflow, !res.byte_valid, "overflow word carries a byte")
  // starting a frame needs a queued record and issues a store read
  `CFTQ_ASSERT(a_start_reads, clk, rst_n, accept && sts.phase == PH_IDLE && res.byte_valid, !sts.empty && mem_req.re, "frame start without store read")
  // no read and write of the same entry in one cycle
  `CFTQ_ASSERT(a_no_rw_clash, clk, rst_n, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr, "store read/write clash")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for command_frame_transmit_queue: queued records and slot ticks checked byte by byte.
module testbench
  import cftq_pkg::*;
();

  typedef struct packed {
    logic       operation;
    logic [7:0] command;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] data2;
  } word_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_data;

  cftq_in_if  in_ch ();
  cftq_out_if out_ch ();

  command_frame_transmit_queue u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // frame predictor state
  logic [31:0] rec_store [FIFO_DEPTH_DEF];
  logic [3:0]  wr_ptr;
  logic [3:0]  rd_ptr;
  logic [2:0]  frame_pos;
  logic [31:0] cur_rec;
  logic [7:0]  marker;

  word_t pending_words[$];
  res_t  expected_res[$];
  word_t held;
  int    in_flight;
  int    errors;
  int    n_enq, n_tick, n_results, n_frames, n_dropped;
  int unsigned burst_left, gap_left;
  int unsigned rx_mode, rx_cycle, hold_cnt;
  bit    held_off;
  logic [7:0] last_marker;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Advance the predictor by one accepted word and return the byte slot it yields.
  function automatic res_t frame_step(word_t w);
    res_t       r;
    logic [3:0] nxt;
    logic [7:0] sum;
    r = '0;
    if (w.operation == OP_ENQ) begin
      nxt = wr_ptr + 4'd1;
      if (nxt == rd_ptr) begin
        r.overflow = 1'b1;
      end else begin
        rec_store[wr_ptr] = {w.data2, w.data1, w.data0, w.command};
        wr_ptr = nxt;
      end
    end else begin
      case (frame_pos)
        PH_IDLE: begin
          if (wr_ptr != rd_ptr) begin
            cur_rec = rec_store[rd_ptr];
            rd_ptr = rd_ptr + 4'd1;
            r.tx_byte = marker;
            r.byte_valid = 1'b1;
            frame_pos = PH_START2;
          end
        end
        PH_START2: begin
          r.tx_byte = marker;
          r.byte_valid = 1'b1;
          frame_pos = PH_CMD;
        end
        PH_CMD, PH_D0, PH_D1, PH_D2: begin
          r.tx_byte = cur_rec[(frame_pos - PH_CMD) * 8 +: 8];
          r.byte_valid = 1'b1;
          frame_pos = frame_pos + 3'd1;
        end
        PH_SUM: begin
          sum = cur_rec[7:0] + cur_rec[15:8] + cur_rec[23:16] + cur_rec[31:24];
          r.tx_byte = sum;
          r.byte_valid = 1'b1;
          r.last_of_frame = 1'b1;
          frame_pos = PH_IDLE;
        end
        default: frame_pos = PH_IDLE;
      endcase
    end
    r.queue_count = wr_ptr - rd_ptr;
    return r;
  endfunction

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // driver: bursts of words with random gaps
  always @(posedge clk) begin : drive
    word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(frame_step(held));
        if (held.operation == OP_ENQ) n_enq++;
        else n_tick++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          w = pending_words.pop_front();
          held = w;
          in_flight++;
          in_ch.operation <= w.operation;
          in_ch.command   <= w.command;
          in_ch.data0     <= w.data0;
          in_ch.data1     <= w.data1;
          in_ch.data2     <= w.data2;
          in_ch.valid     <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor: every accepted result against the oldest prediction
  always @(posedge clk) begin : watch
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      in_flight--;
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual %0h", $time,
                 {out_ch.tx_byte, out_ch.byte_valid, out_ch.last_of_frame,
                  out_ch.overflow, out_ch.queue_count});
      end else begin
        want = expected_res.pop_front();
        check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
        check_field("last_of_frame", 8'(want.last_of_frame), 8'(out_ch.last_of_frame));
        check_field("overflow", 8'(want.overflow), 8'(out_ch.overflow));
        check_field("queue_count", 8'(want.queue_count), 8'(out_ch.queue_count));
        if (want.last_of_frame) n_frames++;
        if (want.overflow) n_dropped++;
      end
    end
  end

  // receiver: stall pattern redrawn at random from time to time, one long hold-off
  always @(posedge clk) begin : sink_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
    end else begin
      rx_cycle++;
      if (rx_cycle % 48 == 0) rx_mode = $urandom_range(0, 3);
      if (!held_off && n_results >= 400) begin
        hold_cnt = 120;
        held_off = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic push_word(logic op, logic [7:0] c, logic [7:0] d0, logic [7:0] d1,
                           logic [7:0] d2);
    word_t w;
    w = {op, c, d0, d1, d2};
    pending_words.push_back(w);
  endtask

  task automatic push_rand(logic op);
    push_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // whole frames (records then enough ticks) most often, plus fill bursts, tick runs and noise
  task automatic random_items(int n);
    int left, k, kind;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        k = $urandom_range(1, 3);
        repeat (k) push_rand(OP_ENQ);
        repeat (7 * k) push_rand(OP_TICK);
        left -= 8 * k;
      end else if (kind < 55) begin
        k = $urandom_range(10, 18);
        repeat (k) push_rand(OP_ENQ);
        left -= k;
      end else if (kind < 75) begin
        k = $urandom_range(7, 40);
        repeat (k) push_rand(OP_TICK);
        left -= k;
      end else begin
        push_rand(1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // drain, then finish any frame in flight so the marker changes between frames
  task automatic close_phase();
    wait_drained();
    if (frame_pos != PH_IDLE) begin
      repeat (7 - frame_pos) push_word(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_drained();
    end
  endtask

  task automatic write_marker(logic [7:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    marker = v;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ENQ;
    in_ch.command   = 8'h00;
    in_ch.data0     = 8'h00;
    in_ch.data1     = 8'h00;
    in_ch.data2     = 8'h00;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = 8'h00;
    wr_ptr          = '0;
    rd_ptr          = '0;
    frame_pos       = PH_IDLE;
    cur_rec         = '0;
    marker          = START_BYTE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // tick on an empty idle queue, then all-zero, all-one and mixed records
    push_word(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(OP_ENQ, 8'h00, 8'h00, 8'h00, 8'h00);
    push_word(OP_ENQ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(OP_ENQ, 8'hA5, 8'h5A, 8'h01, 8'h80);
    repeat (3) push_word(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    // record pushed while a frame is going out
    push_word(OP_ENQ, 8'h01, 8'h02, 8'h04, 8'h08);
    repeat (18) push_word(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    random_items(250);
    close_phase();

    write_marker(8'h00);
    random_items(250);
    close_phase();

    write_marker(8'hFF);
    random_items(250);
    close_phase();

    last_marker = 8'($urandom_range(1, 254));
    write_marker(last_marker);
    random_items(350);
    close_phase();
    repeat (8) @(posedge clk);

    $display("covered %0d record pushes (%0d dropped on a full queue) and %0d slot ticks",
             n_enq, n_dropped, n_tick);
    $display("%0d frames sent with start markers 170, 0, 255 and %0d", n_frames, last_marker);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
